// ===== rtl/csm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the cycle sync monitor.
// No dependencies; every other file imports this package.
package csm_pkg;

	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 344;
	localparam int ADDR_W     = 5;
	localparam int DIV_STEPS  = 64;

	localparam logic [3:0] ID_FORMAT = 4'd1;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_MAINS = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [2:0] REG_GROUP      = 3'd0;
	localparam logic [2:0] REG_LEN_MIN    = 3'd1;
	localparam logic [2:0] REG_LEN_MAX    = 3'd2;
	localparam logic [2:0] REG_START_DIFF = 3'd3;
	localparam logic [2:0] REG_OFFSET_LIM = 3'd4;
	localparam logic [2:0] REG_MAINS_DIFF = 3'd5;
	localparam logic [2:0] REG_POST_TRIG  = 3'd6;
	localparam logic [2:0] REG_WARMUP     = 3'd7;

	localparam int FLAG_START_LEN  = 0;
	localparam int FLAG_START_DIFF = 1;
	localparam int FLAG_OFFSET     = 2;
	localparam int FLAG_MISSING    = 3;
	localparam int FLAG_MAINS_LEN  = 4;
	localparam int FLAG_MAINS_DIFF = 5;

	typedef struct packed {
		logic [11:0] group;
		logic [30:0] len_min;
		logic [30:0] len_max;
		logic [30:0] start_diff;
		logic [30:0] offset_lim;
		logic [30:0] mains_diff;
		logic [29:0] post_trig;
		logic [7:0]  warmup;
	} csm_cfg_t;

	typedef struct packed {
		logic eval;
		logic mdiv_go;
		logic mean_first;
		logic mean_upd;
		logic mul_clr;
		logic mul_step;
		logic sq_add;
		logic vdiv_go;
		logic sqrt_go;
		logic sdev_load;
		logic sdev_zero;
		logic out_load;
	} csm_cmd_t;

	typedef struct packed {
		logic stats_run;
		logic stats_first;
		logic do_mul;
		logic sdev_run;
		logic div_done;
		logic mul_last;
		logic sqrt_done;
	} csm_sts_t;

	// first field in the highest bits
	typedef struct packed {
		logic [39:0]        sdev;
		logic signed [39:0] mean;
		logic signed [31:0] off_max;
		logic signed [31:0] off_min;
		logic [31:0]        match_count;
		logic [31:0]        mains_count;
		logic [31:0]        start_count;
		logic signed [31:0] last_offset;
		logic signed [31:0] mains_len;
		logic signed [31:0] start_len;
		logic [5:0]         flags;
		logic               accepted;
	} csm_result_t;

	function automatic logic csm_out_range(logic signed [31:0] v, logic [30:0] lo,
			logic [30:0] hi);
		return (v < $signed({1'b0, lo})) || (v > $signed({1'b0, hi}));
	endfunction

	function automatic logic csm_over(logic signed [31:0] v, logic [30:0] lim);
		logic signed [32:0] vv;
		logic signed [32:0] l;
		vv = 33'(v);
		l  = $signed({2'b00, lim});
		return (vv < -l) || (vv > l);
	endfunction

endpackage

// ===== rtl/cycle_sync_monitor.sv =====
`timescale 1ns / 1ps
// Top level of the cycle sync monitor: register port, sequencer, datapath, result register.
// Uses csm_pkg, csm_ctrl and csm_dp.

// Each event item yields exactly one result item carrying the accepted bit,
// the latest limit flags, the latest cycle lengths and offset, the three event counters
// and the offset statistics (min and max in ns; mean and standard deviation in ns with
// FRACTION_BITS fraction bits). One item is worked on at a time. Once two or more
// offsets have been measured, each item needs a 64-step divide plus a square root of
// (64+FRACTION_BITS+1)/2 steps in integer division, and an item that adds a new offset
// adds a second 64-step divide and, when its deviations from the old and new mean share
// a sign, a multiply. The shared bit-serial divider and the square-root unit set the
// time an item takes. A finished result waits in the output register while the next
// item is already taken in.
// Registers sit at byte address 4*i; write them only while the block is idle.
module cycle_sync_monitor #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// event_id [63:0], deadline_ns [127:64]
	input  logic [csm_pkg::IN_DATA_W-1:0]  s_tdata,
	// event_kind [1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// accepted [0], limit_flags [6:1], start_cycle_len [38:7], mains_cycle_len [70:39],
	// last_offset [102:71], start_count [134:103], mains_count [166:135],
	// match_count [198:167], offset_min [230:199], offset_max [262:231],
	// offset_mean [302:263], offset_sdev [342:303], zero [343]
	output logic [csm_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [csm_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import csm_pkg::*;

	csm_cfg_t    cfg_q;
	csm_cmd_t    cmd;
	csm_sts_t    sts;
	csm_result_t res;
	csm_result_t out_q;
	logic        out_valid_q;
	logic        out_free;
	logic        wr_en;

	// Register port: write on the access cycle, no wait states
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group      <= 12'd0;
			cfg_q.len_min    <= 31'd19000000;
			cfg_q.len_max    <= 31'd21000000;
			cfg_q.start_diff <= 31'd100000;
			cfg_q.offset_lim <= 31'd100000;
			cfg_q.mains_diff <= 31'd100000;
			cfg_q.post_trig  <= 30'd0;
			cfg_q.warmup     <= 8'd2;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_GROUP:      cfg_q.group      <= pwdata[11:0];
				REG_LEN_MIN:    cfg_q.len_min    <= pwdata[30:0];
				REG_LEN_MAX:    cfg_q.len_max    <= pwdata[30:0];
				REG_START_DIFF: cfg_q.start_diff <= pwdata[30:0];
				REG_OFFSET_LIM: cfg_q.offset_lim <= pwdata[30:0];
				REG_MAINS_DIFF: cfg_q.mains_diff <= pwdata[30:0];
				REG_POST_TRIG:  cfg_q.post_trig  <= pwdata[29:0];
				REG_WARMUP:     cfg_q.warmup     <= pwdata[7:0];
				default:        cfg_q.group      <= cfg_q.group;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_GROUP:      prdata = 32'(cfg_q.group);
			REG_LEN_MIN:    prdata = 32'(cfg_q.len_min);
			REG_LEN_MAX:    prdata = 32'(cfg_q.len_max);
			REG_START_DIFF: prdata = 32'(cfg_q.start_diff);
			REG_OFFSET_LIM: prdata = 32'(cfg_q.offset_lim);
			REG_MAINS_DIFF: prdata = 32'(cfg_q.mains_diff);
			REG_POST_TRIG:  prdata = 32'(cfg_q.post_trig);
			REG_WARMUP:     prdata = 32'(cfg_q.warmup);
			default:        prdata = '0;
		endcase
	end

	// Sequencer: takes an item only when idle, hands the result over when the
	// output register is free
	assign out_free = !out_valid_q || m_tready;

	csm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	csm_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.kind        (s_tuser),
		.event_id    (s_tdata[63:0]),
		.deadline_ns (s_tdata[127:64]),
		.sts         (sts),
		.res         (res)
	);

	// Result register: hold the item until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

	// One item in flight: the sequencer leaves idle right after taking one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken while another is in work");

	// A result is never loaded over one that the sink has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// With fewer than two offsets the deviation reads zero
	a_sdev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[198:167] == 32'd0 || m_tdata[198:167] == 32'd1)
		|-> m_tdata[342:303] == 40'd0)
		else $error("deviation nonzero before two matches");
endmodule

// ===== rtl/csm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// Uses csm_pkg.
module csm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [63:0] quotient,
	output logic        done
);
	import csm_pkg::*;

	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[63]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && cnt_q == 7'd1;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

// ===== rtl/csm_sqrt.sv =====
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one root bit per cycle.
// Uses csm_pkg.
module csm_sqrt #(
	parameter int RW = 72
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [RW-1:0]   radicand,
	output logic [RW/2-1:0] root,
	output logic            done
);
	import csm_pkg::*;

	localparam int SW = RW / 2;
	localparam int H  = SW + 3;
	localparam int CW = $clog2(SW + 1);

	logic [RW-1:0] rad_q;
	logic [H-1:0]  rem_q;
	logic [SW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [H-1:0]  shifted;
	logic [H-1:0]  trial;
	logic          fits;

	assign shifted = {rem_q[H-3:0], rad_q[RW-1:RW-2]};
	assign trial   = H'({root_q, 2'b01});
	assign fits    = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && cnt_q == CW'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? shifted - trial : shifted;
			root_q <= {root_q[SW-2:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

// ===== rtl/csm_dp.sv =====
`timescale 1ns / 1ps
// Datapath: event evaluation, limit flags, counters and offset statistics.
// Uses csm_pkg, csm_div and csm_sqrt; driven by commands from csm_ctrl.
module csm_dp #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csm_pkg::csm_cfg_t     cfg,
	input  csm_pkg::csm_cmd_t     cmd,
	input  logic [1:0]            kind,
	input  logic [63:0]           event_id,
	input  logic [63:0]           deadline_ns,
	output csm_pkg::csm_sts_t     sts,
	output csm_pkg::csm_result_t  res
);
	import csm_pkg::*;

	localparam int W  = 32 + FRACTION_BITS;
	localparam int RW = 2 * ((64 + FRACTION_BITS + 1) / 2);
	localparam int SW = RW / 2;

	logic [63:0]        start_prev_q, mains_prev_q;
	logic signed [31:0] start_len_q, mains_len_q, last_off_q, min_q, max_q;
	logic               pending_q, accepted_q, stats_run_q;
	logic [5:0]         flags_q;
	logic [31:0]        cnt_start_q, cnt_mains_q, cnt_match_q;
	logic signed [W-1:0] mean_q, v_q;
	logic [63:0]        sq_q;
	logic signed [W:0]  a_q;
	logic [63:0]        ma_q, mb_q, pp_q;
	logic [1:0]         pidx_q;
	logic [2:0]         mcnt_q;
	logic [127:0]       acc_q;
	logic [39:0]        sdev_q;

	logic               pass;
	logic               ev_accept, ev_match;
	logic signed [31:0] s_len, s_diff, m_len, m_diff, off;
	logic [31:0]        s_cnt, m_cnt;
	logic [63:0]        act;
	logic signed [W-1:0] v_new;
	logic signed [W:0]  a_now, b_now;
	logic [W:0]         mag_a, mag_b, q_div;
	logic [63:0]        div_dividend, div_quot;
	logic [31:0]        div_divisor;
	logic               div_done, sqrt_done;
	logic [SW-1:0]      root;
	logic [31:0]        a_half, b_half;
	logic [127:0]       pp_shifted, prod_sh;
	logic [64:0]        sq_sum;

	assign pass   = (event_id[63:60] == ID_FORMAT) && (event_id[59:48] == cfg.group);
	assign s_len  = $signed(deadline_ns[31:0] - start_prev_q[31:0]);
	assign s_diff = s_len - start_len_q;
	assign s_cnt  = cnt_start_q + 32'd1;
	assign act    = deadline_ns - 64'(cfg.post_trig);
	assign m_len  = $signed(act[31:0] - mains_prev_q[31:0]);
	assign m_diff = m_len - mains_len_q;
	assign m_cnt  = cnt_mains_q + 32'd1;
	assign off    = $signed(start_prev_q[31:0] - act[31:0]);
	assign v_new  = W'(off) <<< FRACTION_BITS;

	// accepted start or mains event, and a mains event that measures an offset
	assign ev_accept = (kind == KIND_START || kind == KIND_MAINS) && pass;
	assign ev_match  = kind == KIND_MAINS && pass && pending_q &&
		(m_cnt > 32'(cfg.warmup) + 32'd1);

	assign a_now = (W + 1)'(v_q) - (W + 1)'(mean_q);
	assign b_now = (W + 1)'(v_q) - (W + 1)'(mean_q);
	assign mag_a = a_now[W] ? (W + 1)'(-a_now) : a_now;
	assign mag_b = b_now[W] ? (W + 1)'(-b_now) : b_now;
	assign q_div = div_quot[W:0];

	assign div_dividend = cmd.vdiv_go ? sq_q : 64'(mag_a) + 64'(cnt_match_q >> 1);
	assign div_divisor  = cmd.vdiv_go ? cnt_match_q - 32'd1 : cnt_match_q;

	csm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mdiv_go | cmd.vdiv_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	csm_sqrt #(.RW(RW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_go),
		.radicand (RW'(div_quot) << FRACTION_BITS),
		.root     (root),
		.done     (sqrt_done)
	);

	// four 32x32 partial products; each is registered before it is added to the sum
	assign a_half = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign b_half = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];

	always_comb begin
		case (pidx_q)
			2'd0:    pp_shifted = 128'(pp_q);
			2'd3:    pp_shifted = 128'(pp_q) << 64;
			default: pp_shifted = 128'(pp_q) << 32;
		endcase
	end

	assign prod_sh = acc_q >> FRACTION_BITS;
	assign sq_sum  = 65'(sq_q) + 65'(prod_sh[63:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_prev_q <= '0;
			mains_prev_q <= '0;
			start_len_q  <= '0;
			mains_len_q  <= '0;
			last_off_q   <= '0;
			pending_q    <= 1'b0;
			flags_q      <= '0;
			cnt_start_q  <= '0;
			cnt_mains_q  <= '0;
			cnt_match_q  <= '0;
			min_q        <= 32'sh7fffffff;
			max_q        <= 32'sh80000000;
			mean_q       <= '0;
			sq_q         <= '0;
			accepted_q   <= 1'b0;
			stats_run_q  <= 1'b0;
			sdev_q       <= '0;
		end else begin
			if (cmd.eval) begin
				accepted_q  <= ev_accept;
				stats_run_q <= ev_match;
				if (kind == KIND_CLEAR) begin
					cnt_start_q <= '0;
					cnt_mains_q <= '0;
					cnt_match_q <= '0;
					min_q       <= 32'sh7fffffff;
					max_q       <= 32'sh80000000;
					mean_q      <= '0;
					sq_q        <= '0;
				end else if (kind == KIND_START && pass) begin
					cnt_start_q  <= s_cnt;
					if (s_cnt > 32'(cfg.warmup)) begin
						pending_q <= 1'b1;
						flags_q[FLAG_START_LEN]  <= csm_out_range(s_len, cfg.len_min,
							cfg.len_max);
						flags_q[FLAG_START_DIFF] <= csm_over(s_diff, cfg.start_diff);
					end
					start_len_q  <= s_len;
					start_prev_q <= deadline_ns;
				end else if (kind == KIND_MAINS && pass) begin
					cnt_mains_q <= m_cnt;
					if (m_cnt > 32'(cfg.warmup) + 32'd1) begin
						flags_q[FLAG_MAINS_LEN]  <= csm_out_range(m_len, cfg.len_min,
							cfg.len_max);
						flags_q[FLAG_MAINS_DIFF] <= csm_over(m_diff, cfg.mains_diff);
						flags_q[FLAG_MISSING]    <= !pending_q;
						if (pending_q) begin
							last_off_q  <= off;
							flags_q[FLAG_OFFSET] <= csm_over(off, cfg.offset_lim);
							cnt_match_q <= cnt_match_q + 32'd1;
							if (off < min_q) min_q <= off;
							if (off > max_q) max_q <= off;
							pending_q   <= 1'b0;
						end
					end
					mains_len_q  <= m_len;
					mains_prev_q <= act;
				end
			end
			if (cmd.mean_first) begin
				mean_q <= v_q;
				sq_q   <= '0;
			end
			if (cmd.mean_upd) begin
				mean_q <= a_q[W] ? mean_q - W'(q_div) : mean_q + W'(q_div);
			end
			if (cmd.sq_add) begin
				// saturate the sum of squares
				if (prod_sh[127:64] != '0 || sq_sum[64]) sq_q <= '1;
				else sq_q <= sq_sum[63:0];
			end
			if (cmd.sdev_load) sdev_q <= 40'(root);
			if (cmd.sdev_zero) sdev_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) v_q <= v_new;
		if (cmd.mdiv_go) a_q <= a_now;
		if (cmd.mul_clr) begin
			ma_q   <= 64'(a_q[W] ? (W + 1)'(-a_q) : a_q);
			mb_q   <= 64'(mag_b);
			acc_q  <= '0;
			mcnt_q <= '0;
		end else if (cmd.mul_step) begin
			pp_q   <= a_half * b_half;
			pidx_q <= mcnt_q[1:0];
			mcnt_q <= mcnt_q + 3'd1;
			if (mcnt_q != 3'd0) acc_q <= acc_q + pp_shifted;
		end
	end

	assign sts.stats_run   = stats_run_q;
	assign sts.stats_first = cnt_match_q <= 32'd1;
	assign sts.do_mul      = (a_q > 0 && b_now > 0) || (a_q < 0 && b_now < 0);
	assign sts.sdev_run    = cnt_match_q > 32'd1;
	assign sts.div_done    = div_done;
	assign sts.mul_last    = mcnt_q == 3'd4;
	assign sts.sqrt_done   = sqrt_done;

	assign res.accepted    = accepted_q;
	assign res.flags       = flags_q;
	assign res.start_len   = start_len_q;
	assign res.mains_len   = mains_len_q;
	assign res.last_offset = last_off_q;
	assign res.start_count = cnt_start_q;
	assign res.mains_count = cnt_mains_q;
	assign res.match_count = cnt_match_q;
	assign res.off_min     = min_q;
	assign res.off_max     = max_q;
	assign res.mean        = 40'(mean_q);
	assign res.sdev        = sdev_q;
endmodule

// ===== rtl/csm_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for one event: evaluate, update the statistics, compute the deviation.
// Uses csm_pkg.
module csm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_free,
	input  csm_pkg::csm_sts_t sts,
	output logic              in_ready,
	output csm_pkg::csm_cmd_t cmd
);
	import csm_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_BR    = 11'b000_0000_0010,
		ST_MWAIT = 11'b000_0000_0100,
		ST_MEAN  = 11'b000_0000_1000,
		ST_CHK   = 11'b000_0001_0000,
		ST_MUL   = 11'b000_0010_0000,
		ST_SQADD = 11'b000_0100_0000,
		ST_SDEV  = 11'b000_1000_0000,
		ST_VWAIT = 11'b001_0000_0000,
		ST_RWAIT = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} csm_state_t;

	csm_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.eval = 1'b1;
					state_d  = ST_BR;
				end
			end
			ST_BR: begin
				if (!sts.stats_run) begin
					state_d = ST_SDEV;
				end else if (sts.stats_first) begin
					cmd.mean_first = 1'b1;
					state_d        = ST_SDEV;
				end else begin
					cmd.mdiv_go = 1'b1;
					state_d     = ST_MWAIT;
				end
			end
			ST_MWAIT: begin
				if (sts.div_done) state_d = ST_MEAN;
			end
			ST_MEAN: begin
				cmd.mean_upd = 1'b1;
				state_d      = ST_CHK;
			end
			ST_CHK: begin
				cmd.mul_clr = 1'b1;
				state_d     = sts.do_mul ? ST_MUL : ST_SDEV;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) state_d = ST_SQADD;
			end
			ST_SQADD: begin
				cmd.sq_add = 1'b1;
				state_d    = ST_SDEV;
			end
			ST_SDEV: begin
				if (sts.sdev_run) begin
					cmd.vdiv_go = 1'b1;
					state_d     = ST_VWAIT;
				end else begin
					cmd.sdev_zero = 1'b1;
					state_d       = ST_DONE;
				end
			end
			ST_VWAIT: begin
				if (sts.div_done) begin
					cmd.sqrt_go = 1'b1;
					state_d     = ST_RWAIT;
				end
			end
			ST_RWAIT: begin
				if (sts.sqrt_done) begin
					cmd.sdev_load = 1'b1;
					state_d       = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign in_ready = state_q == ST_IDLE;
endmodule
